// ===== hw/rtl/prpf_pkg.sv =====
// ---------------------------------------------------------------------------
// prpf_pkg: shared types and constants of the polar ROI point filter
// Beat structs, configuration layout, CORDIC arctangent table.
// ---------------------------------------------------------------------------
package prpf_pkg;

	localparam int COORD_BITS       = 16;
	localparam int CFG_BITS         = 16;
	localparam int CFG_IDX_W        = 3;
	localparam int FRAC_BITS        = 16;
	localparam int CORDIC_STEPS_DEF = 18;
	localparam int ROT_W            = COORD_BITS + 1;
	localparam int CW               = COORD_BITS + FRAC_BITS + 3;
	localparam int ACC_W            = 26;
	localparam int BRG_W            = 17;
	localparam int SQ_W             = 2 * COORD_BITS;
	localparam int RSUM_W           = SQ_W + 1;
	localparam int MID_DEPTH        = 4;

	localparam logic signed [BRG_W-1:0] HALF_TURN    = BRG_W'(18000);
	localparam logic signed [BRG_W-1:0] QUARTER_TURN = BRG_W'(9000);
	localparam logic signed [ACC_W-1:0] HALF_ACC     = ACC_W'(18000 * 256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEIGHT_LOW   = 3'd0,
		REG_HEIGHT_HIGH  = 3'd1,
		REG_BEARING_LOW  = 3'd2,
		REG_BEARING_HIGH = 3'd3,
		REG_REACH_LOW    = 3'd4,
		REG_REACH_HIGH   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CFG_BITS-1:0] height_low;
		logic signed [CFG_BITS-1:0] height_high;
		logic signed [CFG_BITS-1:0] bearing_low;
		logic signed [CFG_BITS-1:0] bearing_high;
		logic [CFG_BITS-1:0]        reach_low;
		logic [CFG_BITS-1:0]        reach_high;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
		logic                         cloud_end;
	} in_beat_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic signed [COORD_BITS-1:0] out_z;
		logic                         keep;
		logic                         out_end;
	} out_beat_t;

	// what the front hands the back through the middle queue
	typedef struct packed {
		in_beat_t                 pt;
		logic                     height_ok;
		logic [SQ_W-1:0]          sq_x;
		logic [SQ_W-1:0]          sq_y;
		logic                     fixed;
		logic signed [BRG_W-1:0]  fixed_val;
		logic signed [ROT_W-1:0]  rot_x;
		logic signed [ROT_W-1:0]  rot_y;
		logic signed [ACC_W-1:0]  acc_init;
	} mid_t;

	// side data that rides along the CORDIC stages
	typedef struct packed {
		in_beat_t                pt;
		logic                    height_ok;
		logic                    range_ok;
		logic                    fixed;
		logic signed [BRG_W-1:0] fixed_val;
	} meta_t;

	// atan(2^-i) in units of 1/256 of 0.01 degree
	function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
		logic signed [ACC_W-1:0] v;
		case (i)
			0: v = ACC_W'(1152000);
			1: v = ACC_W'(680065);
			2: v = ACC_W'(359328);
			3: v = ACC_W'(182400);
			4: v = ACC_W'(91554);
			5: v = ACC_W'(45822);
			6: v = ACC_W'(22916);
			7: v = ACC_W'(11459);
			8: v = ACC_W'(5730);
			9: v = ACC_W'(2865);
			10: v = ACC_W'(1432);
			11: v = ACC_W'(716);
			12: v = ACC_W'(358);
			13: v = ACC_W'(179);
			14: v = ACC_W'(90);
			15: v = ACC_W'(45);
			16: v = ACC_W'(22);
			17: v = ACC_W'(11);
			18: v = ACC_W'(6);
			19: v = ACC_W'(3);
			20: v = ACC_W'(1);
			21: v = ACC_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/polar_roi_point_filter.sv =====
// ---------------------------------------------------------------------------
// polar_roi_point_filter: height / planar range / bearing crop of lidar points
// Marks each point with keep; coordinates and end mark pass unchanged.
// ---------------------------------------------------------------------------
// One point is taken per clock while full is low, and one result beat leaves
// per clock while popped. From push to the head of the result queue a
// point passes the middle queue, one entry stage, CORDIC_STEPS vectoring
// stages and one rounding stage. Full rises only when the 4-entry middle queue
// fills, which happens when the result queue (32 entries, credited) is not
// being popped. Every point yields exactly one beat, in order. keep is 1 when
// height_low <= z <= height_high, reach_low^2 <= x^2+y^2 <= reach_high^2
// (exact) and bearing_low <= bearing <= bearing_high, bearing = atan2(y,x) in
// 0.01 degree from a fixed-point CORDIC. A bound pair with low above high
// rejects everything. Registers are written through cfg_we/cfg_idx/cfg_data;
// the user must write them only while no point is in flight, the block does
// not enforce this. Index 0..5 = height_low, height_high, bearing_low,
// bearing_high, reach_low, reach_high; other indexes are ignored.
module polar_roi_point_filter import prpf_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  in_beat_t             in_beat,
	output logic                 empty,
	input  logic                 pop,
	output out_beat_t            out_beat,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]  cfg_data
);
	localparam int OUT_DEPTH = 32;

	cfg_t      cfg_q;
	mid_t      mid_w, mid_r;
	logic      mid_empty, mid_pop;
	logic      res_wr, res_full;
	out_beat_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height_low   <= CFG_BITS'(0);
			cfg_q.height_high  <= CFG_BITS'(1500);
			cfg_q.bearing_low  <= -CFG_BITS'(6000);
			cfg_q.bearing_high <= CFG_BITS'(6000);
			cfg_q.reach_low    <= CFG_BITS'(100);
			cfg_q.reach_high   <= CFG_BITS'(1500);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HEIGHT_LOW:   cfg_q.height_low   <= cfg_data;
				REG_HEIGHT_HIGH:  cfg_q.height_high  <= cfg_data;
				REG_BEARING_LOW:  cfg_q.bearing_low  <= cfg_data;
				REG_BEARING_HIGH: cfg_q.bearing_high <= cfg_data;
				REG_REACH_LOW:    cfg_q.reach_low    <= cfg_data;
				REG_REACH_HIGH:   cfg_q.reach_high   <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: classify the incoming beat
	prpf_front u_front (
		.pt  (in_beat),
		.cfg (cfg_q),
		.cls (mid_w)
	);

	// middle queue decouples the front from the CORDIC pipeline
	prpf_fifo #(
		.WIDTH ($bits(mid_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (mid_w),
		.full  (full),
		.rd    (mid_pop),
		.rdata (mid_r),
		.empty (mid_empty)
	);

	// back: range check, bearing and decision
	prpf_back #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.OUT_DEPTH    (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid       (mid_r),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.res_pop   (pop && !empty),
		.res_wr    (res_wr),
		.res       (res)
	);

	// result queue; credits in the back keep it from overflowing
	prpf_fifo #(
		.WIDTH ($bits(out_beat_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_wr),
		.wdata (res),
		.full  (res_full),
		.rd    (pop),
		.rdata (out_beat),
		.empty (empty)
	);

	logic unused_full;
	assign unused_full = res_full;
endmodule

// ===== hw/rtl/prpf_fifo.sv =====
// ---------------------------------------------------------------------------
// prpf_fifo: small synchronous queue
// Register-array FIFO with count; DEPTH must be a power of two.
// ---------------------------------------------------------------------------
module prpf_fifo import prpf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end
endmodule

// ===== hw/rtl/prpf_front.sv =====
// ---------------------------------------------------------------------------
// prpf_front: point classification
// Height test, coordinate squares, axis cases and half-plane rotation.
// ---------------------------------------------------------------------------
module prpf_front import prpf_pkg::*; (
	input  in_beat_t pt,
	input  cfg_t     cfg,
	output mid_t     cls
);
	logic                    x_neg, y_neg;
	logic [COORD_BITS-1:0]   ax, ay;
	logic signed [ROT_W-1:0] ex, ey;

	always_comb begin
		x_neg = pt.pos_x[COORD_BITS-1];
		y_neg = pt.pos_y[COORD_BITS-1];
		ex    = ROT_W'(pt.pos_x);
		ey    = ROT_W'(pt.pos_y);
		// |v| of the most negative code is 2^(N-1), still fits N unsigned bits
		ax    = x_neg ? COORD_BITS'(-ex) : COORD_BITS'(ex);
		ay    = y_neg ? COORD_BITS'(-ey) : COORD_BITS'(ey);

		cls.pt        = pt;
		cls.height_ok = (pt.pos_z >= cfg.height_low) && (pt.pos_z <= cfg.height_high);
		cls.sq_x      = SQ_W'(ax) * SQ_W'(ax);
		cls.sq_y      = SQ_W'(ay) * SQ_W'(ay);

		// on an axis the bearing is exact
		cls.fixed     = 1'b0;
		cls.fixed_val = '0;
		if (pt.pos_y == '0) begin
			cls.fixed     = 1'b1;
			cls.fixed_val = x_neg ? HALF_TURN : '0;
		end else if (pt.pos_x == '0) begin
			cls.fixed     = 1'b1;
			cls.fixed_val = y_neg ? -QUARTER_TURN : QUARTER_TURN;
		end

		// fold the left half plane onto the right one
		cls.rot_x    = x_neg ? -ex : ex;
		cls.rot_y    = x_neg ? -ey : ey;
		cls.acc_init = x_neg ? (y_neg ? -HALF_ACC : HALF_ACC) : '0;
	end
endmodule

// ===== hw/rtl/prpf_back.sv =====
// ---------------------------------------------------------------------------
// prpf_back: range check, CORDIC bearing pipeline and final decision
// Free-running pipeline; issue is gated by credits on the result queue.
// ---------------------------------------------------------------------------
module prpf_back import prpf_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int OUT_DEPTH    = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  mid_t      mid,
	input  logic      mid_empty,
	output logic      mid_pop,
	input  logic      res_pop,
	output logic      res_wr,
	output out_beat_t res
);
	localparam int CRW = $clog2(OUT_DEPTH + 1);

	logic [CRW-1:0]          credit_q;
	logic [SQ_W-1:0]         rlo_q, rhi_q;
	logic [RSUM_W-1:0]       rsum;

	logic                    vld_s [CORDIC_STEPS+1];
	meta_t                   meta_s [CORDIC_STEPS+1];
	logic signed [CW-1:0]    cx_s [CORDIC_STEPS+1];
	logic signed [CW-1:0]    cy_s [CORDIC_STEPS+1];
	logic signed [ACC_W-1:0] acc_s [CORDIC_STEPS+1];

	logic                    vld_r;
	meta_t                   meta_r;
	logic signed [BRG_W-1:0] brg_r;
	logic signed [ACC_W-1:0] nacc, racc;
	logic signed [BRG_W-1:0] brg;

	assign mid_pop = !mid_empty && (credit_q != '0);
	assign rsum    = RSUM_W'(mid.sq_x) + RSUM_W'(mid.sq_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CRW'(OUT_DEPTH);
		end else begin
			credit_q <= credit_q - CRW'(mid_pop) + CRW'(res_pop);
		end
	end

	// squared limits; the user must keep config static while items flow, the block does not enforce this
	always_ff @(posedge clk) begin
		rlo_q <= SQ_W'(cfg.reach_low) * SQ_W'(cfg.reach_low);
		rhi_q <= SQ_W'(cfg.reach_high) * SQ_W'(cfg.reach_high);
	end

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= mid_pop;
		end
	end

	always_ff @(posedge clk) begin
		meta_s[0].pt        <= mid.pt;
		meta_s[0].height_ok <= mid.height_ok;
		meta_s[0].range_ok  <= (rsum >= RSUM_W'(rlo_q)) && (rsum <= RSUM_W'(rhi_q));
		meta_s[0].fixed     <= mid.fixed;
		meta_s[0].fixed_val <= mid.fixed_val;
		cx_s[0]  <= {CW'(mid.rot_x)} <<< FRAC_BITS;
		cy_s[0]  <= {CW'(mid.rot_y)} <<< FRAC_BITS;
		acc_s[0] <= mid.acc_init;
	end

	// one vectoring step per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			meta_s[i+1] <= meta_s[i];
			if (cy_s[i] > 0) begin
				cx_s[i+1]  <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1]  <= cy_s[i] - (cx_s[i] >>> i);
				acc_s[i+1] <= acc_s[i] + atan_entry(i);
			end else begin
				cx_s[i+1]  <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1]  <= cy_s[i] + (cx_s[i] >>> i);
				acc_s[i+1] <= acc_s[i] - atan_entry(i);
			end
		end
	end

	// round to 0.01 degree, ties away from zero
	always_comb begin
		nacc = -acc_s[CORDIC_STEPS];
		if (acc_s[CORDIC_STEPS] >= 0) begin
			racc = (acc_s[CORDIC_STEPS] + ACC_W'(128)) >>> 8;
			brg  = BRG_W'(racc);
		end else begin
			racc = (nacc + ACC_W'(128)) >>> 8;
			brg  = -BRG_W'(racc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r <= 1'b0;
		end else begin
			vld_r <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		meta_r <= meta_s[CORDIC_STEPS];
		brg_r  <= meta_s[CORDIC_STEPS].fixed ? meta_s[CORDIC_STEPS].fixed_val : brg;
	end

	assign res_wr      = vld_r;
	assign res.out_x   = meta_r.pt.pos_x;
	assign res.out_y   = meta_r.pt.pos_y;
	assign res.out_z   = meta_r.pt.pos_z;
	assign res.out_end = meta_r.pt.cloud_end;
	assign res.keep    = meta_r.height_ok && meta_r.range_ok
		&& (brg_r >= BRG_W'(cfg.bearing_low)) && (brg_r <= BRG_W'(cfg.bearing_high));
endmodule
